// ===== rtl/lsae_pkg.sv =====
// Package: constants, codes and types for the linear sensor auto exposure block.
`default_nettype none

package lsae_pkg;

    localparam int PIXEL_COUNT    = 256;
    localparam int ADC_FULL_SCALE = 4095;
    localparam int EDGE_MARGIN    = 10;

    localparam int IDX_W  = $clog2(PIXEL_COUNT);
    localparam int PIX_W  = 12;
    localparam int SET_W  = 16;
    localparam int TIME_W = 14;
    localparam int THR_W  = 16;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(PIXEL_COUNT - 1);
    localparam logic [IDX_W:0]   WIN_LO    = (IDX_W + 1)'(EDGE_MARGIN);
    localparam logic [IDX_W:0]   WIN_HI    = (IDX_W + 1)'((PIXEL_COUNT > EDGE_MARGIN)
                                             ? (PIXEL_COUNT - EDGE_MARGIN) : 0);

    localparam logic [THR_W-1:0] PEAK_HI = THR_W'(ADC_FULL_SCALE * 90 / 100);
    localparam logic [THR_W-1:0] PEAK_LO = THR_W'(ADC_FULL_SCALE * 30 / 100);

    localparam logic [TIME_W-1:0] TIME_MIN   = 14'd500;
    localparam logic [TIME_W-1:0] TIME_MAX   = 14'd10000;
    localparam logic [TIME_W-1:0] TIME_RESET = 14'd2000;

    // x/5 == (x * RECIP5) >> 18, exact for 16-bit x
    localparam logic [15:0] RECIP5 = 16'd52429;
    localparam int          RECIP5_SH = 18;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_SET   = 1'b1;

    typedef logic [1:0] t_adj;
    localparam t_adj ADJ_NONE     = 2'd0;
    localparam t_adj ADJ_SHORTEN  = 2'd1;
    localparam t_adj ADJ_LENGTHEN = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/linear_sensor_auto_exposure.sv =====
// Top level: peak-based auto exposure over frames of linear sensor pixel samples.
// Pipeline: an accepted request waits in the input register and moves to the result
// register when that is empty or its result is taken. Throughput: one request per cycle
// while the output is not stalled; input register and result register each hold one
// request, so two requests can wait during an output stall before the input stalls.
// Reset (synchronous, active low): pixel index 0, running peak 0, time 2000 us,
// both pipeline stages empty.
`default_nettype none

module linear_sensor_auto_exposure (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [11:0] pixel, [27:12] set_time, [31:28] zero
    input  wire logic [lsae_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [0] mode
    input  wire logic                               i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // [13:0] integration_time, [25:14] frame_peak, [31:26] zero
    output logic [lsae_pkg::OUT_DATA_W-1:0]         o_m_axis_tdata,
    // frame_done
    output logic                                    o_m_axis_tlast,
    // [1:0] adjustment
    output logic [1:0]                              o_m_axis_tuser
);
    import lsae_pkg::*;

    logic                 r_in_valid;
    logic                 r_mode;
    logic [PIX_W-1:0]     r_pixel;
    logic [SET_W-1:0]     r_set;

    logic [IDX_W-1:0]     r_idx;
    logic [PIX_W-1:0]     r_peak;
    logic [TIME_W-1:0]    r_time;

    logic                 r_out_valid;
    logic [TIME_W-1:0]    r_out_time;
    logic [PIX_W-1:0]     r_out_peak;
    logic                 r_out_done;
    t_adj                 r_out_adj;

    logic                 w_adv;
    logic                 w_take;
    logic                 w_in_win;
    logic                 w_last;
    logic [PIX_W-1:0]     w_peak_upd;
    logic [15:0]          w_x4;
    logic [15:0]          w_x6;
    logic [31:0]          w_prod_dn;
    logic [31:0]          w_prod_up;
    logic [TIME_W-1:0]    w_dn;
    logic [TIME_W-1:0]    w_up;
    logic [TIME_W-1:0]    w_set_clamp;

    logic [IDX_W-1:0]     n_idx;
    logic [PIX_W-1:0]     n_peak;
    logic [TIME_W-1:0]    n_time;
    logic [PIX_W-1:0]     n_out_peak;
    logic                 n_out_done;
    t_adj                 n_out_adj;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    assign w_in_win   = ({1'b0, r_idx} >= WIN_LO) && ({1'b0, r_idx} < WIN_HI);
    assign w_peak_upd = (w_in_win && (r_pixel > r_peak)) ? r_pixel : r_peak;
    assign w_last     = (r_idx == IDX_LAST);

    assign w_x4      = {r_time, 2'b00};
    assign w_x6      = {r_time, 2'b00} + {1'b0, r_time, 1'b0};
    assign w_prod_dn = 32'(w_x4) * 32'(RECIP5);
    assign w_prod_up = 32'(w_x6) * 32'(RECIP5);
    assign w_dn      = (w_prod_dn[RECIP5_SH +: TIME_W] < TIME_MIN) ? TIME_MIN
                                                               : w_prod_dn[RECIP5_SH +: TIME_W];
    assign w_up      = (w_prod_up[RECIP5_SH +: TIME_W] > TIME_MAX) ? TIME_MAX
                                                               : w_prod_up[RECIP5_SH +: TIME_W];

    always_comb begin
        if (r_set < 16'(TIME_MIN)) begin
            w_set_clamp = TIME_MIN;
        end else if (r_set > 16'(TIME_MAX)) begin
            w_set_clamp = TIME_MAX;
        end else begin
            w_set_clamp = r_set[TIME_W-1:0];
        end
    end

    always_comb begin
        n_idx      = r_idx;
        n_peak     = r_peak;
        n_time     = r_time;
        n_out_peak = r_peak;
        n_out_done = 1'b0;
        n_out_adj  = ADJ_NONE;
        if (r_mode == MODE_SET) begin
            n_time = w_set_clamp;
        end else begin
            n_out_peak = w_peak_upd;
            if (w_last) begin
                n_out_done = 1'b1;
                n_idx      = '0;
                n_peak     = '0;
                if ((THR_W'(w_peak_upd) > PEAK_HI) && (r_time > TIME_MIN)) begin
                    n_time    = w_dn;
                    n_out_adj = ADJ_SHORTEN;
                end else if ((THR_W'(w_peak_upd) < PEAK_LO) && (r_time < TIME_MAX)) begin
                    n_time    = w_up;
                    n_out_adj = ADJ_LENGTHEN;
                end
            end else begin
                n_idx  = r_idx + 1'b1;
                n_peak = w_peak_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_peak      <= '0;
            r_time      <= TIME_RESET;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_idx       <= n_idx;
                r_peak      <= n_peak;
                r_time      <= n_time;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mode  <= i_s_axis_tuser;
            r_pixel <= i_s_axis_tdata[PIX_W-1:0];
            r_set   <= i_s_axis_tdata[PIX_W +: SET_W];
        end
        if (w_adv) begin
            r_out_time <= n_time;
            r_out_peak <= n_out_peak;
            r_out_done <= n_out_done;
            r_out_adj  <= n_out_adj;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - TIME_W - PIX_W)'(0), r_out_peak, r_out_time};
    assign o_m_axis_tlast  = r_out_done;
    assign o_m_axis_tuser  = r_out_adj;

endmodule

`default_nettype wire

// ===== rtl/lsae_checker.sv =====
// Checker: port-level assertions for the auto exposure block, bound to the top level.
`default_nettype none

module lsae_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_m_axis_tvalid,
    input wire logic                               i_m_axis_tready,
    input wire logic [lsae_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input wire logic                               o_m_axis_tlast,
    input wire logic [1:0]                         o_m_axis_tuser
);
    import lsae_pkg::*;

    logic [TIME_W-1:0] w_time;
    logic [PIX_W-1:0]  w_peak;

    assign w_time = o_m_axis_tdata[TIME_W-1:0];
    assign w_peak = o_m_axis_tdata[TIME_W +: PIX_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result request dropped while stalled");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((w_time >= TIME_MIN) && (w_time <= TIME_MAX)))
        else $error("integration time out of range");

    a_adj_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ADJ_NONE)) |-> o_m_axis_tlast)
        else $error("adjustment outside frame end");

    a_shorten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ADJ_SHORTEN)) |->
            (THR_W'(w_peak) > PEAK_HI))
        else $error("shortened without bright peak");

    a_lengthen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ADJ_LENGTHEN)) |->
            (THR_W'(w_peak) < PEAK_LO))
        else $error("lengthened without dim peak");

endmodule

bind linear_sensor_auto_exposure lsae_checker u_lsae_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
